// ----- sv/tcgr_pkg.sv -----
// shared constants, codes and color functions of the text console glyph renderer
`default_nettype none

package tcgr_pkg;

  localparam int GLYPH_HEIGHT = 16;
  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_COUNT  = 256;

  localparam int FONT_DEPTH  = 2 * GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int FONT_AW     = $clog2(FONT_DEPTH);
  localparam int ROW_W       = $clog2(GLYPH_HEIGHT);
  localparam int FETCH_W     = $clog2(GLYPH_HEIGHT + 1);
  localparam int LINE_CMP_W  = (ROW_W + 1 > 4) ? ROW_W + 1 : 4;
  localparam int ROWPIX_W    = $clog2(GLYPH_HEIGHT * 256);

  localparam int PITCH_W     = 14;
  localparam int COLS_W      = 10;
  localparam int ROWS_W      = 9;
  localparam int MODE_W      = 2;
  localparam int PROD_W      = PITCH_W + ROWPIX_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int OFF_W       = 24;
  localparam int COLOUR_W    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd3;

  localparam logic [PITCH_W-1:0] PITCH_RST = 14'd640;
  localparam logic [COLS_W-1:0]  COLS_RST  = 10'd80;
  localparam logic [ROWS_W-1:0]  ROWS_RST  = 9'd30;

  localparam logic [1:0] REQ_CHAR    = 2'd0;
  localparam logic [1:0] REQ_FONT    = 2'd1;
  localparam logic [1:0] REQ_NEWLINE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_32 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_16 = 2'd1;

  localparam logic KIND_ROW   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [7:0] CODE_ESC       = 8'h01;
  localparam logic [7:0] CODE_FG_MAX    = 8'h0F;
  localparam logic [7:0] CODE_BOLD_OFF  = 8'h10;
  localparam logic [7:0] CODE_BOLD_ON   = 8'h11;
  localparam logic [3:0] FG_RST         = 4'd15;

  function automatic logic [COLOUR_W-1:0] palette(input logic [3:0] idx);
    logic [COLOUR_W-1:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'h0000AA;
      4'd2:    c = 24'h00AA00;
      4'd3:    c = 24'h00AAAA;
      4'd4:    c = 24'hAA0000;
      4'd5:    c = 24'hAA00AA;
      4'd6:    c = 24'hAA5500;
      4'd7:    c = 24'hAAAAAA;
      4'd8:    c = 24'h555555;
      4'd9:    c = 24'h5555FF;
      4'd10:   c = 24'h55FF55;
      4'd11:   c = 24'h55FFFF;
      4'd12:   c = 24'hFF5555;
      4'd13:   c = 24'hFF55FF;
      4'd14:   c = 24'hFFFF55;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] to565(input logic [COLOUR_W-1:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

`default_nettype wire

// ----- sv/tcgr_ifs.sv -----
// valid/ready channel interfaces for requests and glyph row results
`default_nettype none

interface tcgr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;
  logic       font_select;
  logic [3:0] glyph_line;
  logic [7:0] glyph_bits;

  modport source (output valid, req_type, char_code, font_select, glyph_line, glyph_bits,
                  input ready);
  modport sink   (input valid, req_type, char_code, font_select, glyph_line, glyph_bits,
                  output ready);
endinterface

interface tcgr_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [23:0] word_offset;
  logic [7:0]  pixel_mask;
  logic [23:0] pixel_colour;
  logic        last_of_run;

  modport source (output valid, result_kind, word_offset, pixel_mask, pixel_colour,
                  last_of_run, input ready);
  modport sink   (input valid, result_kind, word_offset, pixel_mask, pixel_colour,
                  last_of_run, output ready);
endinterface

`default_nettype wire

// ----- sv/text_console_glyph_renderer_unit.sv -----
// top level of the text console glyph renderer: cursor, escape decode, font memory, row emitter
// in modes 32 and 16 a printed byte passes ST_MUL for its offset, then ST_RUN emits its glyph rows
//   from the font memory, one row a cycle while the output is not stalled; no new request is taken
//   until the rows and any trailing clear result have been handed on to the output register
// escape bytes, font writes and newlines without a clear leave the unit idle
// reset is synchronous: configuration registers, cursor, color and flags return to their reset values,
//   the font memory keeps its contents and holds nothing defined until written
`default_nettype none

module text_console_glyph_renderer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  tcgr_in_if.sink                        in_ch,
  tcgr_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tcgr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_CLR  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [PITCH_W-1:0]   pitch_r;
  logic [COLS_W-1:0]    cols_r;
  logic [ROWS_W-1:0]    rows_r;
  logic [MODE_W-1:0]    mode_r;
  logic [8:0]           col_r, col_nxt;
  logic [7:0]           row_r, row_nxt;
  logic [3:0]           fg_r, fg_nxt;
  logic                 bold_r, bold_nxt;
  logic                 esc_r, esc_nxt;
  logic                 clr_pend_r, clr_pend_nxt;
  logic                 rv_r, rv_nxt;
  logic [FETCH_W-1:0]   fetch_r, fetch_nxt;
  logic [ROW_W-1:0]     emit_r, emit_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [8:0]           draw_col_r, draw_col_nxt;
  logic [7:0]           draw_row_r, draw_row_nxt;
  logic [FONT_AW-1:0]   glyph_base_r, glyph_base_nxt;
  logic [COLOUR_W-1:0]  colour_r, colour_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [OFF_W-1:0]     out_off_r, out_off_nxt;
  logic [7:0]           out_mask_r, out_mask_nxt;
  logic [COLOUR_W-1:0]  out_colour_r, out_colour_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 accept, out_free, load, issue, clr_load;
  logic [9:0]           next_col;
  logic [8:0]           next_row;
  logic                 col_wrap, row_wrap;
  logic [7:0]           nl_row;
  logic [ROWPIX_W-1:0]  rowpix;
  logic [PROD_W-1:0]    prod;
  logic [OFF_W-1:0]     colx;
  logic [COLOUR_W-1:0]  pal;
  logic                 font_we;
  logic [FONT_AW-1:0]   font_waddr, font_raddr;
  logic [7:0]           font_rdata;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign load     = (state_r == ST_RUN) && rv_r && out_free;
  assign issue    = (state_r == ST_RUN) && (fetch_r < FETCH_W'(GLYPH_HEIGHT)) && (!rv_r || load);
  assign clr_load = (state_r == ST_CLR) && out_free;

  assign next_col = {1'b0, col_r} + 10'd1;
  assign col_wrap = (next_col >= cols_r) || next_col[9];
  assign next_row = {1'b0, row_r} + 9'd1;
  assign row_wrap = (next_row >= rows_r) || next_row[8];
  assign nl_row   = row_wrap ? 8'd0 : next_row[7:0];

  assign rowpix = ROWPIX_W'(ROWPIX_W'(draw_row_r) * ROWPIX_W'(GLYPH_HEIGHT));
  assign prod   = PROD_W'(pitch_r) * PROD_W'(rowpix);
  assign colx   = (mode_r == MODE_32) ? OFF_W'({draw_col_r, 3'b000})
                                      : OFF_W'({draw_col_r, 2'b00});
  assign pal    = palette(fg_r);

  assign font_we    = accept && (in_ch.req_type == REQ_FONT) &&
                      (LINE_CMP_W'(in_ch.glyph_line) < LINE_CMP_W'(GLYPH_HEIGHT));
  assign font_waddr = FONT_AW'(FONT_AW'({in_ch.font_select, in_ch.char_code}) *
                               FONT_AW'(GLYPH_HEIGHT)) + FONT_AW'(in_ch.glyph_line);
  assign font_raddr = glyph_base_r + FONT_AW'(fetch_r);

  tcgr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (in_ch.glyph_bits),
    .re    (issue),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    fg_nxt         = fg_r;
    bold_nxt       = bold_r;
    esc_nxt        = esc_r;
    clr_pend_nxt   = clr_pend_r;
    rv_nxt         = rv_r;
    fetch_nxt      = fetch_r;
    emit_nxt       = emit_r;
    draw_col_nxt   = draw_col_r;
    draw_row_nxt   = draw_row_r;
    glyph_base_nxt = glyph_base_r;
    colour_nxt     = colour_r;
    off_nxt        = off_r;

    case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.req_type == REQ_NEWLINE) begin
          col_nxt   = 9'd0;
          row_nxt   = nl_row;
          state_nxt = row_wrap ? ST_CLR : ST_IDLE;
        end else if (accept && in_ch.req_type == REQ_CHAR) begin
          if (in_ch.char_code == CODE_ESC) begin
            esc_nxt = 1'b1;
          end else if (esc_r) begin
            esc_nxt = 1'b0;
            if (in_ch.char_code inside {[8'h00:CODE_FG_MAX]}) begin
              fg_nxt = in_ch.char_code[3:0];
            end else if (in_ch.char_code == CODE_BOLD_OFF) begin
              bold_nxt = 1'b0;
            end else if (in_ch.char_code == CODE_BOLD_ON) begin
              bold_nxt = 1'b1;
            end
          end else begin
            draw_col_nxt   = col_r;
            draw_row_nxt   = row_r;
            glyph_base_nxt = FONT_AW'(FONT_AW'({bold_r, in_ch.char_code}) *
                                      FONT_AW'(GLYPH_HEIGHT));
            colour_nxt     = (mode_r == MODE_16) ? COLOUR_W'(to565(pal)) : pal;
            if (col_wrap) begin
              col_nxt      = 9'd0;
              row_nxt      = nl_row;
              clr_pend_nxt = row_wrap;
            end else begin
              col_nxt      = next_col[8:0];
              clr_pend_nxt = 1'b0;
            end
            if (mode_r inside {MODE_32, MODE_16}) begin
              state_nxt = ST_MUL;
            end else if (col_wrap && row_wrap) begin
              state_nxt = ST_CLR;
            end
          end
        end
      end
      ST_MUL: begin
        off_nxt   = OFF_W'(prod) + colx;
        fetch_nxt = '0;
        emit_nxt  = '0;
        rv_nxt    = 1'b0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (issue) begin
          fetch_nxt = fetch_r + FETCH_W'(1);
          rv_nxt    = 1'b1;
        end else if (load) begin
          rv_nxt = 1'b0;
        end
        if (load) begin
          emit_nxt = emit_r + ROW_W'(1);
          off_nxt  = off_r + OFF_W'(pitch_r);
          if (emit_r == ROW_W'(GLYPH_HEIGHT - 1)) begin
            state_nxt = clr_pend_r ? ST_CLR : ST_IDLE;
          end
        end
      end
      ST_CLR: begin
        if (clr_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_off_nxt    = out_off_r;
    out_mask_nxt   = out_mask_r;
    out_colour_nxt = out_colour_r;
    out_last_nxt   = out_last_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_ROW;
      out_off_nxt    = off_r;
      out_mask_nxt   = font_rdata;
      out_colour_nxt = colour_r;
      out_last_nxt   = (emit_r == ROW_W'(GLYPH_HEIGHT - 1)) && !clr_pend_r;
    end else if (clr_load) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_CLEAR;
      out_off_nxt    = '0;
      out_mask_nxt   = '0;
      out_colour_nxt = '0;
      out_last_nxt   = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pitch_r     <= PITCH_RST;
      cols_r      <= COLS_RST;
      rows_r      <= ROWS_RST;
      mode_r      <= MODE_32;
      col_r       <= '0;
      row_r       <= '0;
      fg_r        <= FG_RST;
      bold_r      <= 1'b0;
      esc_r       <= 1'b0;
      clr_pend_r  <= 1'b0;
      rv_r        <= 1'b0;
      fetch_r     <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      fg_r        <= fg_nxt;
      bold_r      <= bold_nxt;
      esc_r       <= esc_nxt;
      clr_pend_r  <= clr_pend_nxt;
      rv_r        <= rv_nxt;
      fetch_r     <= fetch_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PITCH: pitch_r <= cfg_wdata[PITCH_W-1:0];
          CFG_COLS:  cols_r  <= cfg_wdata[COLS_W-1:0];
          CFG_ROWS:  rows_r  <= cfg_wdata[ROWS_W-1:0];
          CFG_MODE:  mode_r  <= cfg_wdata[MODE_W-1:0];
          default:   mode_r  <= mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    draw_col_r   <= draw_col_nxt;
    draw_row_r   <= draw_row_nxt;
    glyph_base_r <= glyph_base_nxt;
    colour_r     <= colour_nxt;
    off_r        <= off_nxt;
    out_kind_r   <= out_kind_nxt;
    out_off_r    <= out_off_nxt;
    out_mask_r   <= out_mask_nxt;
    out_colour_r <= out_colour_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.word_offset  = out_off_r;
  assign out_ch.pixel_mask   = out_mask_r;
  assign out_ch.pixel_colour = out_colour_r;
  assign out_ch.last_of_run  = out_last_r;

endmodule

`default_nettype wire

// ----- sv/tcgr_ram.sv -----
// generic simple dual-port ram with registered read and read enable
`default_nettype none

module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/tcgr_chk.sv -----
// port-level checker for the glyph renderer and its bind to the top level
`default_nettype none

module tcgr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [23:0] word_offset,
  input logic [7:0]  pixel_mask,
  input logic [23:0] pixel_colour,
  input logic        last_of_run
);
  import tcgr_pkg::*;

  // clear result carries an empty payload and ends its run
  a_clear_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == KIND_CLEAR) |->
      last_of_run && (word_offset == '0) && (pixel_mask == '0) && (pixel_colour == '0))
    else $error("clear result with nonzero payload or not last");

  // more results pending, so no new request is taken
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_of_run |-> !in_ready)
    else $error("request taken while a run is still open");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(word_offset) && $stable(pixel_mask) && $stable(last_of_run))
    else $error("stalled result changed");

  // nothing offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind text_console_glyph_renderer_unit tcgr_chk u_tcgr_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_kind  (out_ch.result_kind),
  .word_offset  (out_ch.word_offset),
  .pixel_mask   (out_ch.pixel_mask),
  .pixel_colour (out_ch.pixel_colour),
  .last_of_run  (out_ch.last_of_run)
);

`default_nettype wire

// ----- bench/tb_text_console_glyph_renderer_unit.sv -----
// testbench for the text console glyph renderer: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb_text_console_glyph_renderer_unit;
  import tcgr_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 30;
  localparam int TAIL_CYCLES   = 40;
  localparam int RANDOM_PHASES = 2;
  localparam int OPS_PER_PHASE = 12;

  localparam logic [1:0]        REQ_UNKNOWN = 2'd3;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE_HI = 2'd3;

  typedef struct {
    logic        kind;
    logic [23:0] offset;
    logic [7:0]  mask;
    logic [23:0] color;
    logic        last;
  } row_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcgr_in_if  in_ch ();
  tcgr_out_if out_ch ();

  text_console_glyph_renderer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predicted console state
  logic [7:0]       glyph_rows [0:FONT_DEPTH-1];
  bit               glyph_written [0:FONT_DEPTH-1];
  logic [PITCH_W-1:0] pitch_q;
  logic [COLS_W-1:0]  cols_q;
  logic [ROWS_W-1:0]  rows_q;
  logic [MODE_W-1:0]  mode_q;
  logic [8:0]       cur_col;
  logic [7:0]       cur_row;
  logic [3:0]       fg_idx;
  logic             bold_q;
  logic             esc_q;

  row_result_t pending_rows [$];
  int mismatches;
  int gap_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [23:0] text_color(input logic [3:0] idx);
    case (idx)
      4'd0:    return 24'h000000;
      4'd1:    return 24'h0000AA;
      4'd2:    return 24'h00AA00;
      4'd3:    return 24'h00AAAA;
      4'd4:    return 24'hAA0000;
      4'd5:    return 24'hAA00AA;
      4'd6:    return 24'hAA5500;
      4'd7:    return 24'hAAAAAA;
      4'd8:    return 24'h555555;
      4'd9:    return 24'h5555FF;
      4'd10:   return 24'h55FF55;
      4'd11:   return 24'h55FFFF;
      4'd12:   return 24'hFF5555;
      4'd13:   return 24'hFF55FF;
      4'd14:   return 24'hFFFF55;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic void push_row(input logic kind, input logic [23:0] offset,
                                   input logic [7:0] mask, input logic [23:0] color);
    row_result_t r;
    r.kind = kind;
    r.offset = offset;
    r.mask = mask;
    r.color = color;
    r.last = 1'b0;
    pending_rows.push_back(r);
  endfunction

  function automatic void next_line();
    int nxt;
    nxt = cur_row + 1;
    cur_col = '0;
    if (nxt >= rows_q || nxt > 255) begin
      cur_row = '0;
      push_row(KIND_CLEAR, '0, '0, '0);
    end else begin
      cur_row = nxt[7:0];
    end
  endfunction

  function automatic void render_request(input logic [1:0] req, input logic [7:0] code,
                                         input logic fsel, input logic [3:0] line,
                                         input logic [7:0] bits);
    int n0;
    int nxt;
    int y;
    int unsigned off;
    int unsigned colx;
    logic [23:0] color;
    row_result_t tail;
    n0 = pending_rows.size();
    if (req == REQ_FONT) begin
      glyph_rows[{fsel, code, line}] = bits;
      glyph_written[{fsel, code, line}] = 1'b1;
    end else if (req == REQ_NEWLINE) begin
      next_line();
    end else if (req == REQ_CHAR) begin
      if (code == CODE_ESC) begin
        esc_q = 1'b1;
      end else if (esc_q) begin
        if (code <= CODE_FG_MAX) fg_idx = code[3:0];
        else if (code == CODE_BOLD_OFF) bold_q = 1'b0;
        else if (code == CODE_BOLD_ON) bold_q = 1'b1;
        esc_q = 1'b0;
      end else begin
        if (mode_q == MODE_32 || mode_q == MODE_16) begin
          color = text_color(fg_idx);
          colx = GLYPH_WIDTH * cur_col;
          if (mode_q == MODE_16) begin
            color = {8'h00, color[23:19], color[15:10], color[7:3]};
            colx = colx >> 1;
          end
          for (y = 0; y < GLYPH_HEIGHT; y++) begin
            off = pitch_q * (GLYPH_HEIGHT * cur_row + y) + colx;
            push_row(KIND_ROW, off[23:0], glyph_rows[{bold_q, code, y[3:0]}], color);
          end
        end
        nxt = cur_col + 1;
        if (nxt >= cols_q || nxt > 511) next_line();
        else cur_col = nxt[8:0];
      end
    end
    if (pending_rows.size() > n0) begin
      tail = pending_rows.pop_back();
      tail.last = 1'b1;
      pending_rows.push_back(tail);
    end
  endfunction

  function automatic bit glyph_loaded(input logic fsel, input logic [7:0] code);
    int l;
    for (l = 0; l < GLYPH_HEIGHT; l++)
      if (!glyph_written[{fsel, code, l[3:0]}]) return 1'b0;
    return 1'b1;
  endfunction

  // glyphs kept loaded for random printing: regular A and bold zero
  function automatic logic [7:0] loaded_code();
    return bold_q ? 8'h00 : 8'h41;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    row_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected result", out_ch.word_offset, '0);
      end else begin
        want = pending_rows.pop_front();
        if (out_ch.result_kind !== want.kind)
          report_mismatch("result_kind", out_ch.result_kind, want.kind);
        if (out_ch.word_offset !== want.offset)
          report_mismatch("word_offset", out_ch.word_offset, want.offset);
        if (out_ch.pixel_mask !== want.mask)
          report_mismatch("pixel_mask", out_ch.pixel_mask, want.mask);
        if (out_ch.pixel_colour !== want.color)
          report_mismatch("pixel_colour", out_ch.pixel_colour, want.color);
        if (out_ch.last_of_run !== want.last)
          report_mismatch("last_of_run", out_ch.last_of_run, want.last);
      end
    end
  end

  // result side backpressure
  initial begin : result_stalls
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && $urandom_range(0, 99) < stall_pct) stall = $urandom_range(1, 15);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(input logic [1:0] req, input logic [7:0] code, input logic fsel,
                           input logic [3:0] line, input logic [7:0] bits);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.req_type = req;
    in_ch.char_code = code;
    in_ch.font_select = fsel;
    in_ch.glyph_line = line;
    in_ch.glyph_bits = bits;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    render_request(req, code, fsel, line, bits);
  endtask

  task automatic load_glyph(input logic fsel, input logic [7:0] code);
    int l;
    for (l = 0; l < GLYPH_HEIGHT; l++)
      send_item(REQ_FONT, code, fsel, l[3:0], 8'($urandom));
  endtask

  // a byte that would be drawn gets its glyph loaded first
  task automatic put_byte(input logic [7:0] code);
    if (code != CODE_ESC && !esc_q && !glyph_loaded(bold_q, code)) load_glyph(bold_q, code);
    send_item(REQ_CHAR, code, 1'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic send_newline();
    send_item(REQ_NEWLINE, 8'($urandom), 1'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      CFG_PITCH: pitch_q = value[PITCH_W-1:0];
      CFG_COLS:  cols_q = value[COLS_W-1:0];
      CFG_ROWS:  rows_q = value[ROWS_W-1:0];
      default:   mode_q = value[MODE_W-1:0];
    endcase
  endtask

  task automatic set_screen(input logic [CFG_DATA_W-1:0] pitch, input logic [CFG_DATA_W-1:0] cols,
                            input logic [CFG_DATA_W-1:0] rows, input logic [MODE_W-1:0] mode);
    wait_idle();
    write_reg(CFG_PITCH, pitch);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_MODE, CFG_DATA_W'(mode));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_reset_defaults();
    int l;
    for (l = 0; l < GLYPH_HEIGHT; l++)
      send_item(REQ_FONT, 8'h41, 1'b0, l[3:0], (l == 5) ? 8'h81 : (l[0] ? 8'hFF : 8'h00));
    put_byte(8'h41);
    send_newline();
    put_byte(8'h41);
  endtask

  task automatic test_escape_codes();
    put_byte(CODE_ESC);
    put_byte(8'h00);
    put_byte(8'h41);
    put_byte(CODE_ESC);
    put_byte(CODE_FG_MAX);
    put_byte(CODE_ESC);
    put_byte(CODE_BOLD_ON);
    put_byte(8'h00);
    // a second escape byte keeps the escape armed
    put_byte(CODE_ESC);
    put_byte(CODE_ESC);
    put_byte(8'h04);
    put_byte(CODE_ESC);
    put_byte(8'h12);
    put_byte(CODE_ESC);
    put_byte(CODE_BOLD_OFF);
    put_byte(8'h41);
  endtask

  task automatic test_unknown_request();
    send_item(REQ_UNKNOWN, 8'hFF, 1'b1, 4'hF, 8'hFF);
    send_item(REQ_UNKNOWN, 8'h00, 1'b0, 4'h0, 8'h00);
    send_item(REQ_NEWLINE, 8'hFF, 1'b1, 4'hF, 8'hFF);
    put_byte(8'h41);
  endtask

  task automatic test_tiny_screens();
    set_screen(14'h3FFF, 14'd1, 14'd1, MODE_16);
    put_byte(8'h41);
    put_byte(8'h41);
    set_screen(14'd0, 14'd0, 14'd0, MODE_NONE_HI);
    put_byte(8'h41);
    send_newline();
    set_screen(14'd1, 14'd2, 14'd2, MODE_NONE);
    repeat (3) put_byte(8'h41);
  endtask

  // offsets beyond 24 bits once the row reaches 64 on the widest pitch
  task automatic test_counter_limits();
    set_screen(14'h3FFF, 14'h3FFF, 14'h3FFF, MODE_NONE);
    repeat (64) send_newline();
    set_screen(14'h3FFF, 14'h3FFF, 14'h3FFF, MODE_32);
    put_byte(8'h41);
    set_screen(14'h3FFF, 14'h3FFF, 14'h3FFF, MODE_16);
    put_byte(8'h41);
  endtask

  task automatic random_op();
    int pick;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    code = 8'($urandom);
    if (pick < 45) begin
      put_byte(loaded_code());
    end else if (pick < 60) begin
      put_byte(CODE_ESC);
      put_byte(8'($urandom_range(0, 17)));
    end else if (pick < 70) begin
      send_newline();
    end else if (pick < 80) begin
      send_item(REQ_FONT, code, 1'($urandom), 4'($urandom), 8'($urandom));
    end else if (pick < 85) begin
      send_item(REQ_UNKNOWN, code, 1'($urandom), 4'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      put_byte(CODE_ESC);
      put_byte(8'($urandom_range(18, 255)));
    end else begin
      code = loaded_code();
      send_item(REQ_FONT, code, bold_q, 4'($urandom), 8'($urandom));
      put_byte(code);
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    logic [CFG_DATA_W-1:0] pitch;
    logic [CFG_DATA_W-1:0] cols;
    logic [CFG_DATA_W-1:0] rows;
    logic [MODE_W-1:0] mode;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0:       pitch = 14'd1;
        1:       pitch = 14'd640;
        2:       pitch = 14'h3FFF;
        3:       pitch = 14'd0;
        default: pitch = 14'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0, 1:    cols = 14'($urandom_range(1, 6));
        2:       cols = 14'd80;
        3:       cols = 14'd0;
        default: cols = 14'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 4))
        0, 1:    rows = 14'($urandom_range(1, 4));
        2:       rows = 14'd30;
        3:       rows = 14'd0;
        default: rows = 14'($urandom_range(0, 511));
      endcase
      n = $urandom_range(0, 9);
      if (n < 4) mode = MODE_32;
      else if (n < 8) mode = MODE_16;
      else if (n == 8) mode = MODE_NONE;
      else mode = MODE_NONE_HI;
      set_screen(pitch, cols, rows, mode);
      if (phase == RANDOM_PHASES - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = $urandom_range(0, 2) * 15;
        stall_pct = $urandom_range(0, 2) * 10;
      end
      for (n = 0; n < OPS_PER_PHASE; n++) random_op();
    end
  endtask

  initial begin : main_flow
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PITCH;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_CHAR;
    in_ch.char_code = '0;
    in_ch.font_select = 1'b0;
    in_ch.glyph_line = '0;
    in_ch.glyph_bits = '0;
    pitch_q = PITCH_RST;
    cols_q = COLS_RST;
    rows_q = ROWS_RST;
    mode_q = MODE_32;
    cur_col = '0;
    cur_row = '0;
    fg_idx = FG_RST;
    bold_q = 1'b0;
    esc_q = 1'b0;
    mismatches = 0;
    gap_pct = 25;
    stall_pct = 10;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_escape_codes();
    test_unknown_request();
    test_tiny_screens();
    test_counter_limits();
    test_random_traffic();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
